### design/spa_pkg.sv
// Shared types and constants of the slot pool allocator.
// Holds command and status codes, the sequencer state type and packed words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

    localparam int SLOT_W      = 11;
    localparam int FILE_W      = 64;
    localparam int CMD_W       = 3;
    localparam int CLS_W       = 3;
    localparam int RID_W       = 3;
    localparam int RF_W        = 4;
    localparam int STAT_W      = 2;
    localparam int MASK_W      = 8;
    localparam int CNT_W       = 11;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 88;

    localparam logic [CMD_W-1:0] CMD_TAKE_NEXT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE_AT      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE         = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_TAIL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SLOT_OF_FILE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FILE_OF_SLOT = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FREE_COUNT   = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_ARG   = 2'd3;

    localparam logic [1:0] REG_POOL_SIZE      = 2'd0;
    localparam logic [1:0] REG_CLASSES_IN_USE = 2'd1;
    localparam logic [1:0] REG_IS_PRIMARY     = 2'd2;
    localparam logic [1:0] REG_REPLICA_COUNT  = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [FILE_W-1:0] file;
        logic [MASK_W-1:0] mask;
    } slot_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [FILE_W-1:0] file;
        logic [CNT_W-1:0]  count;
        logic              released;
    } result_t;

endpackage

`default_nettype wire

### design/spa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module spa_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1409
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/slot_pool_allocator_unit.sv
// Top level of the slot pool allocator: stream channels, APB register port,
// command sequencer and scan datapath. Depends on spa_pkg and spa_ram.
//
// Usage. Commands arrive as transactions on the s_ channel (command code in
// s_tuser, arguments in s_tdata); each command yields exactly one result
// transaction on the m_ channel (status in m_tuser, slot, file, count and
// release flag in m_tdata). One command is handled at a time; s_tready is low
// from acceptance until its result has been registered and taken.
// Free count, a full class on take next and every rejected argument are
// answered without reading the slot memory; take at and file of slot read one
// slot; take next probes the class from its next pointer until a free slot is
// found or the class size is used up; free and slot of file scan the slots
// until a match, and remove tail walks every slot. The slot memory has a single
// read port, which the scan unit walks one slot per cycle. A stalled receiver
// simply holds the result in the output register; no new command is taken
// until it leaves.
// After reset the slot memory is swept to zero, one slot per cycle, across all
// TOTAL_SLOTS slots (1409 with the default sizes); no command is accepted
// during that sweep, but register writes are taken as usual.
// Registers must only be written while no command is outstanding.
`timescale 1ns / 1ps
`default_nettype none

module slot_pool_allocator_unit #(
    parameter int SMALL_SLOTS  = 1024,
    parameter int BIG_SLOTS    = 128,
    parameter int SIZE_CLASSES = 4,
    parameter int REPLICAS     = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, low bit up: file_number[63:0], size_class[66:64],
    // slot_index[77:67], replica_id[80:78], tail_replicas[84:81], zero fill.
    input  wire logic [spa_pkg::IN_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd[2:0].
    input  wire logic [spa_pkg::CMD_W-1:0]      s_tuser,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, low bit up: slot_out[10:0], file_out[74:11], count_out[85:75],
    // released[86], zero fill.
    output logic [spa_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tuser: status[1:0].
    output logic [spa_pkg::STAT_W-1:0]          m_tuser,
    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int TOTAL_SLOTS = 1 + SMALL_SLOTS + (SIZE_CLASSES - 1) * BIG_SLOTS;
    localparam int AW          = $clog2(TOTAL_SLOTS);
    localparam int RW          = $clog2(TOTAL_SLOTS + 1);
    localparam int CAP_MAX     = (SMALL_SLOTS > BIG_SLOTS) ? SMALL_SLOTS : BIG_SLOTS;
    localparam int TCW         = $clog2(CAP_MAX + 1);
    localparam int CIW         = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int WORD_W      = $bits(spa_pkg::slot_word_t);

    // First slot of a class: the small pool starts at slot 1, big pools follow it.
    function automatic logic [AW-1:0] class_start(input int unsigned k);
        if (k == 0)
        begin
            return AW'(1);
        end
        return AW'(SMALL_SLOTS + 1 + (k - 1) * BIG_SLOTS);
    endfunction

    function automatic logic [CIW-1:0] class_of_slot(input logic [AW-1:0] s);
        logic [CIW-1:0] r;
        r = '0;
        for (int k = 1; k < SIZE_CLASSES; k++)
        begin
            if (s >= class_start(k))
            begin
                r = CIW'(k);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    spa_pkg::state_t state_reg, state_next;

    logic [spa_pkg::SLOT_W-1:0] pool_size_reg, pool_size_next;
    logic [2:0]                 classes_reg, classes_next;
    logic                       primary_reg, primary_next;
    logic [3:0]                 replicas_reg, replicas_next;
    logic [spa_pkg::MASK_W-1:0] nsm_reg, nsm_next;

    logic [TCW-1:0] taken_count_reg [SIZE_CLASSES];
    logic [TCW-1:0] taken_count_next [SIZE_CLASSES];
    logic [AW-1:0]  next_ptr_reg [SIZE_CLASSES];
    logic [AW-1:0]  next_ptr_next [SIZE_CLASSES];

    logic [AW-1:0] clr_reg, clr_next;
    logic          chk_v_reg, chk_v_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers, no reset needed.
    logic [spa_pkg::CMD_W-1:0]  cmd_reg;
    logic [spa_pkg::FILE_W-1:0] file_reg;
    logic [spa_pkg::CLS_W-1:0]  cls_reg;
    logic [spa_pkg::SLOT_W-1:0] sidx_reg;
    logic [spa_pkg::RID_W-1:0]  rid_reg;
    logic [spa_pkg::RF_W-1:0]   rf_reg;
    logic [AW-1:0]              ip_reg, ip_next;
    logic [AW-1:0]              cp_reg, cp_next;
    logic [AW-1:0]              wst_reg, wst_next;
    logic [AW-1:0]              wen_reg, wen_next;
    logic [RW-1:0]              cnt_reg, cnt_next;
    spa_pkg::result_t           res_reg, res_next;

    // ------------------------------------------------------------------
    // Slot memory: file number and replica mask of every slot.
    // ------------------------------------------------------------------
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    spa_pkg::slot_word_t ram_wdata;
    spa_pkg::slot_word_t ram_rdata;

    spa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TOTAL_SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ip_reg),
        .rdata(ram_rdata)
    );

    // ------------------------------------------------------------------
    // Handshakes and register port
    // ------------------------------------------------------------------
    logic in_acc;
    logic cfg_we;

    assign s_tready = (state_reg == spa_pkg::S_IDLE) && !out_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {1'b0, res_reg.released, res_reg.count, res_reg.file, res_reg.slot};
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            spa_pkg::REG_POOL_SIZE:      prdata = 32'(pool_size_reg);
            spa_pkg::REG_CLASSES_IN_USE: prdata = 32'(classes_reg);
            spa_pkg::REG_IS_PRIMARY:     prdata = 32'(primary_reg);
            spa_pkg::REG_REPLICA_COUNT:  prdata = 32'(replicas_reg);
            default:                     prdata = '0;
        endcase
    end

    // Any register write reloads the mask given to newly taken slots.
    logic [3:0] rc_eff;

    always_comb
    begin
        pool_size_next = pool_size_reg;
        classes_next   = classes_reg;
        primary_next   = primary_reg;
        replicas_next  = replicas_reg;
        if (cfg_we)
        begin
            case (paddr[3:2])
                spa_pkg::REG_POOL_SIZE:      pool_size_next = pwdata[spa_pkg::SLOT_W-1:0];
                spa_pkg::REG_CLASSES_IN_USE: classes_next   = pwdata[2:0];
                spa_pkg::REG_IS_PRIMARY:     primary_next   = pwdata[0];
                spa_pkg::REG_REPLICA_COUNT:  replicas_next  = pwdata[3:0];
                default:                     pool_size_next = pool_size_reg;
            endcase
        end
        if (replicas_next == 4'd0)
        begin
            rc_eff = 4'd1;
        end
        else if (replicas_next > REPLICAS)
        begin
            rc_eff = 4'(REPLICAS);
        end
        else
        begin
            rc_eff = replicas_next;
        end
    end

    // ------------------------------------------------------------------
    // Class decode from the latched command
    // ------------------------------------------------------------------
    logic [2:0]     eff_classes;
    logic           cls_ok;
    logic [CIW-1:0] c_idx;
    logic [TCW-1:0] eff_pool;
    logic [AW-1:0]  st_c;
    logic [AW-1:0]  en_c;
    logic [TCW-1:0] cap_c;
    logic [AW-1:0]  np_c;
    logic [CIW-1:0] tc_idx;
    logic [TCW-1:0] tk_sel;
    logic [spa_pkg::MASK_W-1:0] strip_bit;

    always_comb
    begin
        if (classes_reg == 3'd0)
        begin
            eff_classes = 3'd1;
        end
        else if (classes_reg > SIZE_CLASSES)
        begin
            eff_classes = 3'(SIZE_CLASSES);
        end
        else
        begin
            eff_classes = classes_reg;
        end
        cls_ok = (cls_reg >= 3'd1) && (cls_reg <= eff_classes);
        c_idx  = cls_ok ? CIW'(cls_reg - 3'd1) : '0;

        if (pool_size_reg == '0)
        begin
            eff_pool = TCW'(1);
        end
        else if (pool_size_reg > SMALL_SLOTS)
        begin
            eff_pool = TCW'(SMALL_SLOTS);
        end
        else
        begin
            eff_pool = TCW'(pool_size_reg);
        end

        st_c  = class_start(32'(c_idx));
        en_c  = (c_idx == '0) ? AW'(eff_pool) : st_c + AW'(BIG_SLOTS - 1);
        cap_c = (c_idx == '0) ? eff_pool : TCW'(BIG_SLOTS);
        np_c  = next_ptr_reg[c_idx];

        // Frees and remove tail charge the class that owns the slot.
        if ((cmd_reg == spa_pkg::CMD_FREE) || (cmd_reg == spa_pkg::CMD_REMOVE_TAIL))
        begin
            tc_idx = class_of_slot(cp_reg);
        end
        else
        begin
            tc_idx = c_idx;
        end
        tk_sel    = taken_count_reg[tc_idx];
        strip_bit = spa_pkg::MASK_W'(1) << (rf_reg - 4'd1);
    end

    // ------------------------------------------------------------------
    // Datapath and scan unit
    // ------------------------------------------------------------------
    logic clr_done;
    logic dec_scan;
    logic fin;
    logic hit;
    logic tc_inc;
    logic tc_dec;
    logic [spa_pkg::MASK_W-1:0] new_mask;
    spa_pkg::result_t fres;

    assign clr_done = (clr_reg == AW'(TOTAL_SLOTS - 1));

    always_comb
    begin
        nsm_next         = nsm_reg;
        next_ptr_next    = next_ptr_reg;
        taken_count_next = taken_count_reg;
        clr_next         = clr_reg;
        chk_v_next       = 1'b0;
        rem_next         = rem_reg;
        ip_next          = ip_reg;
        cp_next          = cp_reg;
        wst_next         = wst_reg;
        wen_next         = wen_reg;
        cnt_next         = cnt_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        ram_we           = 1'b0;
        ram_waddr        = cp_reg;
        ram_wdata        = '0;
        dec_scan         = 1'b0;
        fin              = 1'b0;
        hit              = 1'b0;
        tc_inc           = 1'b0;
        tc_dec           = 1'b0;
        new_mask         = '0;
        fres             = '0;

        case (state_reg)
            spa_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end

            spa_pkg::S_DECODE:
            begin
                wst_next = st_c;
                wen_next = en_c;
                cnt_next = '0;
                case (cmd_reg)
                    spa_pkg::CMD_TAKE_NEXT:
                    begin
                        if ((file_reg == '0) || !cls_ok)
                        begin
                            fin         = 1'b1;
                            fres.status = spa_pkg::STAT_BAD_ARG;
                        end
                        else if (tk_sel >= cap_c)
                        begin
                            fin         = 1'b1;
                            fres.status = spa_pkg::STAT_FULL;
                        end
                        else
                        begin
                            dec_scan = 1'b1;
                            ip_next  = ((np_c < st_c) || (np_c > en_c)) ? st_c : np_c;
                            rem_next = RW'(cap_c);
                        end
                    end
                    spa_pkg::CMD_TAKE_AT:
                    begin
                        if ((file_reg == '0) || !cls_ok || (sidx_reg < st_c)
                            || (sidx_reg > en_c))
                        begin
                            fin         = 1'b1;
                            fres.status = spa_pkg::STAT_BAD_ARG;
                        end
                        else
                        begin
                            dec_scan = 1'b1;
                            ip_next  = AW'(sidx_reg);
                            rem_next = RW'(1);
                        end
                    end
                    spa_pkg::CMD_FREE, spa_pkg::CMD_SLOT_OF_FILE:
                    begin
                        if (file_reg == '0)
                        begin
                            fin         = 1'b1;
                            fres.status = spa_pkg::STAT_NOT_FOUND;
                        end
                        else
                        begin
                            dec_scan = 1'b1;
                            ip_next  = AW'(1);
                            rem_next = RW'(TOTAL_SLOTS - 1);
                            wst_next = '0;
                            wen_next = AW'(TOTAL_SLOTS - 1);
                        end
                    end
                    spa_pkg::CMD_REMOVE_TAIL:
                    begin
                        if ((rf_reg < 4'd2) || (rf_reg > REPLICAS))
                        begin
                            fin         = 1'b1;
                            fres.status = spa_pkg::STAT_BAD_ARG;
                        end
                        else
                        begin
                            dec_scan = 1'b1;
                            nsm_next = strip_bit - spa_pkg::MASK_W'(2);
                            ip_next  = '0;
                            rem_next = RW'(TOTAL_SLOTS);
                            wst_next = '0;
                            wen_next = AW'(TOTAL_SLOTS - 1);
                        end
                    end
                    spa_pkg::CMD_FILE_OF_SLOT:
                    begin
                        if (sidx_reg >= TOTAL_SLOTS)
                        begin
                            fin         = 1'b1;
                            fres.status = spa_pkg::STAT_BAD_ARG;
                        end
                        else
                        begin
                            dec_scan = 1'b1;
                            ip_next  = AW'(sidx_reg);
                            rem_next = RW'(1);
                        end
                    end
                    spa_pkg::CMD_FREE_COUNT:
                    begin
                        fin = 1'b1;
                        if (!cls_ok)
                        begin
                            fres.status = spa_pkg::STAT_BAD_ARG;
                        end
                        else if (tk_sel < cap_c)
                        begin
                            fres.count = spa_pkg::CNT_W'(cap_c - tk_sel);
                        end
                    end
                    default:
                    begin
                        fin         = 1'b1;
                        fres.status = spa_pkg::STAT_BAD_ARG;
                    end
                endcase
            end

            spa_pkg::S_SCAN:
            begin
                // Check the word read for the slot issued in the previous cycle.
                if (chk_v_reg)
                begin
                    case (cmd_reg)
                        spa_pkg::CMD_TAKE_NEXT, spa_pkg::CMD_TAKE_AT:
                        begin
                            if ((cmd_reg == spa_pkg::CMD_TAKE_AT) || (ram_rdata.file == '0))
                            begin
                                hit            = 1'b1;
                                ram_we         = 1'b1;
                                ram_wdata.file = file_reg;
                                ram_wdata.mask = nsm_reg;
                                tc_inc         = (ram_rdata.file == '0);
                                next_ptr_next[c_idx] = (cp_reg >= wen_reg) ? wst_reg
                                                                           : cp_reg + AW'(1);
                                fres.slot      = spa_pkg::SLOT_W'(cp_reg);
                            end
                        end
                        spa_pkg::CMD_FREE:
                        begin
                            if (ram_rdata.file == file_reg)
                            begin
                                hit      = 1'b1;
                                ram_we   = 1'b1;
                                new_mask = ram_rdata.mask & ~(spa_pkg::MASK_W'(1) << rid_reg);
                                if (new_mask == '0)
                                begin
                                    tc_dec        = 1'b1;
                                    fres.released = 1'b1;
                                end
                                else
                                begin
                                    ram_wdata.file = ram_rdata.file;
                                    ram_wdata.mask = new_mask;
                                end
                                fres.slot = spa_pkg::SLOT_W'(cp_reg);
                            end
                        end
                        spa_pkg::CMD_SLOT_OF_FILE:
                        begin
                            if (ram_rdata.file == file_reg)
                            begin
                                hit       = 1'b1;
                                fres.slot = spa_pkg::SLOT_W'(cp_reg);
                            end
                        end
                        spa_pkg::CMD_FILE_OF_SLOT:
                        begin
                            hit       = 1'b1;
                            fres.file = ram_rdata.file;
                            fres.slot = spa_pkg::SLOT_W'(cp_reg);
                        end
                        spa_pkg::CMD_REMOVE_TAIL:
                        begin
                            if ((ram_rdata.mask & strip_bit) != '0)
                            begin
                                ram_we   = 1'b1;
                                new_mask = ram_rdata.mask & ~strip_bit;
                                if (new_mask == '0)
                                begin
                                    tc_dec   = 1'b1;
                                    cnt_next = cnt_reg + RW'(1);
                                end
                                else
                                begin
                                    ram_wdata.file = ram_rdata.file;
                                    ram_wdata.mask = new_mask;
                                end
                            end
                        end
                        default:
                        begin
                            hit = 1'b0;
                        end
                    endcase
                end

                if (hit)
                begin
                    fin = 1'b1;
                end
                else if ((rem_reg == '0) && !chk_v_reg)
                begin
                    // Scan exhausted without a match.
                    fin = 1'b1;
                    case (cmd_reg)
                        spa_pkg::CMD_TAKE_NEXT:   fres.status = spa_pkg::STAT_FULL;
                        spa_pkg::CMD_REMOVE_TAIL: fres.count  = spa_pkg::CNT_W'(cnt_reg);
                        default:                  fres.status = spa_pkg::STAT_NOT_FOUND;
                    endcase
                end

                // Issue the next read, wrapping at the end of the search range.
                if ((rem_reg != '0) && !hit)
                begin
                    chk_v_next = 1'b1;
                    cp_next    = ip_reg;
                    ip_next    = (ip_reg >= wen_reg) ? wst_reg : ip_reg + AW'(1);
                    rem_next   = rem_reg - RW'(1);
                end
            end

            default:
            begin
                fin = 1'b0;
            end
        endcase

        if (fin)
        begin
            res_next       = fres;
            out_valid_next = 1'b1;
        end

        if (tc_inc)
        begin
            taken_count_next[tc_idx] = tk_sel + TCW'(1);
        end
        else if (tc_dec && (tk_sel != '0))
        begin
            taken_count_next[tc_idx] = tk_sel - TCW'(1);
        end

        if (cfg_we)
        begin
            nsm_next = primary_next ? ((spa_pkg::MASK_W'(1) << rc_eff) - spa_pkg::MASK_W'(2))
                                    : spa_pkg::MASK_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spa_pkg::S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = spa_pkg::S_IDLE;
                end
            end
            spa_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = spa_pkg::S_DECODE;
                end
            end
            spa_pkg::S_DECODE:
            begin
                state_next = dec_scan ? spa_pkg::S_SCAN : spa_pkg::S_IDLE;
            end
            spa_pkg::S_SCAN:
            begin
                if (fin)
                begin
                    state_next = spa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spa_pkg::S_CLEAR;
            pool_size_reg <= spa_pkg::SLOT_W'(1024);
            classes_reg   <= 3'd1;
            primary_reg   <= 1'b0;
            replicas_reg  <= 4'd1;
            nsm_reg       <= spa_pkg::MASK_W'(1);
            clr_reg       <= '0;
            chk_v_reg     <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SIZE_CLASSES; k++)
            begin
                taken_count_reg[k] <= '0;
                next_ptr_reg[k]    <= class_start(k);
            end
        end
        else
        begin
            state_reg       <= state_next;
            pool_size_reg   <= pool_size_next;
            classes_reg     <= classes_next;
            primary_reg     <= primary_next;
            replicas_reg    <= replicas_next;
            nsm_reg         <= nsm_next;
            clr_reg         <= clr_next;
            chk_v_reg       <= chk_v_next;
            rem_reg         <= rem_next;
            out_valid_reg   <= out_valid_next;
            taken_count_reg <= taken_count_next;
            next_ptr_reg    <= next_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= s_tuser;
            file_reg <= s_tdata[63:0];
            cls_reg  <= s_tdata[66:64];
            sidx_reg <= s_tdata[77:67];
            rid_reg  <= s_tdata[80:78];
            rf_reg   <= s_tdata[84:81];
        end
        ip_reg  <= ip_next;
        cp_reg  <= cp_next;
        wst_reg <= wst_next;
        wen_reg <= wen_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("command accepted while another was outstanding");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spa_pkg::S_CLEAR) |-> !out_valid_reg)
        else $error("result presented during the clearing sweep");

    a_write_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == spa_pkg::S_CLEAR) || (state_reg == spa_pkg::S_SCAN)))
        else $error("slot memory written outside clear or scan");

    a_check_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        chk_v_reg |-> ((state_reg == spa_pkg::S_SCAN) && $past(state_reg == spa_pkg::S_SCAN)))
        else $error("slot check without a read issued in the scan");

endmodule

`default_nettype wire
